FILE: rtl/crash_log_ring_capture_defines.svh
// ---------------------------------------------------------------------------
// crash log ring capture assertion macros
// shared property wrappers for the capture ring checks
// ---------------------------------------------------------------------------
`ifndef CRASH_LOG_RING_CAPTURE_DEFINES_SVH
`define CRASH_LOG_RING_CAPTURE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CRLOG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CRLOG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/crlog_pkg.sv
// ---------------------------------------------------------------------------
// crlog_pkg
// shared constants, types and helpers for the crash log capture ring
// ---------------------------------------------------------------------------
`default_nettype none

package crlog_pkg;

    // ring geometry
    localparam int RING_DEPTH = 512;
    localparam int POS_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = POS_W + 1;
    localparam int ADDR_W     = POS_W + 1;
    localparam int MEM_DEPTH  = 2 << POS_W;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int CAUSE_W = 3;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 10;

    // request commands
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOOT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BOOT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    // reset causes
    localparam logic [CAUSE_W-1:0] CAUSE_CLEAN      = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FIRST_CRASH = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LAST_CRASH = 3'd6;

    // characters for the printable filter
    localparam logic [BYTE_W-1:0] CHAR_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_LOW  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_HIGH = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;

    // memory access issued by the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // result descriptor, the report byte joins it from the registered memory read
    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic               last;
        logic               pend;
        logic [CAUSE_W-1:0] cause;
        logic [LEN_W-1:0]   len;
    } t_res;

    // non-printable bytes other than newline and tab become a dot
    function automatic logic [BYTE_W-1:0] sanitize(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b != CHAR_NL && b != CHAR_TAB && (b < CHAR_LOW || b > CHAR_HIGH)) begin
            r = CHAR_DOT;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/crlog_ram.sv
// ---------------------------------------------------------------------------
// crlog_ram
// generic simple dual port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module crlog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/crlog_ctrl.sv
// ---------------------------------------------------------------------------
// crlog_ctrl
// capture and report state, bank swap and memory address generation
// ---------------------------------------------------------------------------
`default_nettype none

module crlog_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_req_valid,
    input  wire logic [crlog_pkg::CMD_W-1:0]     i_command,
    input  wire logic [crlog_pkg::BYTE_W-1:0]    i_log_byte,
    input  wire logic [crlog_pkg::CAUSE_W-1:0]   i_reset_cause,
    output crlog_pkg::t_mem_req                  o_mem,
    output crlog_pkg::t_res                      o_res
);

    logic                            r_bank;
    logic [crlog_pkg::POS_W-1:0]     r_wpos;
    logic                            r_wrapped;
    logic                            r_armed;
    logic                            r_pvalid;
    logic [crlog_pkg::POS_W-1:0]     r_pstart;
    logic [crlog_pkg::CNT_W-1:0]     r_pcount;
    logic [crlog_pkg::CNT_W-1:0]     r_ridx;
    logic [crlog_pkg::CAUSE_W-1:0]   r_cause;

    logic                            n_bank;
    logic [crlog_pkg::POS_W-1:0]     n_wpos;
    logic                            n_wrapped;
    logic                            n_armed;
    logic                            n_pvalid;
    logic [crlog_pkg::POS_W-1:0]     n_pstart;
    logic [crlog_pkg::CNT_W-1:0]     n_pcount;
    logic [crlog_pkg::CNT_W-1:0]     n_ridx;
    logic [crlog_pkg::CAUSE_W-1:0]   n_cause;

    logic [crlog_pkg::SUM_W-1:0]     rd_sum;
    logic [crlog_pkg::POS_W-1:0]     rd_pos;
    logic                            crash_cause;
    logic                            has_bytes;
    logic                            can_read;

    // ring position of the next report byte
    always_comb begin
        rd_sum = crlog_pkg::SUM_W'(r_pstart) + crlog_pkg::SUM_W'(r_ridx);
        if (rd_sum >= crlog_pkg::SUM_W'(crlog_pkg::RING_DEPTH)) begin
            rd_sum = rd_sum - crlog_pkg::SUM_W'(crlog_pkg::RING_DEPTH);
        end
        rd_pos = rd_sum[crlog_pkg::POS_W-1:0];
    end

    assign crash_cause = (i_reset_cause >= crlog_pkg::CAUSE_FIRST_CRASH) &&
                         (i_reset_cause <= crlog_pkg::CAUSE_LAST_CRASH);
    assign has_bytes   = (r_wpos != '0) || r_wrapped;
    assign can_read    = r_pvalid && (r_ridx < r_pcount);

    // request decode
    always_comb begin
        n_bank    = r_bank;
        n_wpos    = r_wpos;
        n_wrapped = r_wrapped;
        n_armed   = r_armed;
        n_pvalid  = r_pvalid;
        n_pstart  = r_pstart;
        n_pcount  = r_pcount;
        n_ridx    = r_ridx;
        n_cause   = r_cause;
        o_mem       = '0;
        o_mem.waddr = {r_bank, r_wpos};
        o_mem.wdata = i_log_byte;
        o_mem.raddr = {~r_bank, rd_pos};
        o_res       = '0;
        if (i_req_valid) begin
            unique case (i_command)
                crlog_pkg::CMD_APPEND: begin
                    if (r_armed) begin
                        o_mem.we = 1'b1;
                        if (r_wpos == crlog_pkg::POS_W'(crlog_pkg::RING_DEPTH - 1)) begin
                            n_wpos    = '0;
                            n_wrapped = 1'b1;
                        end else begin
                            n_wpos = r_wpos + 1'b1;
                        end
                    end
                end
                crlog_pkg::CMD_BOOT: begin
                    if (crash_cause && r_armed && has_bytes) begin
                        n_pvalid = 1'b1;
                        n_cause  = i_reset_cause;
                        if (r_wrapped) begin
                            n_pstart = r_wpos;
                            n_pcount = crlog_pkg::CNT_W'(crlog_pkg::RING_DEPTH);
                        end else begin
                            n_pstart = '0;
                            n_pcount = crlog_pkg::CNT_W'(r_wpos);
                        end
                        n_bank = ~r_bank;
                    end else begin
                        n_pvalid = 1'b0;
                        n_cause  = crlog_pkg::CAUSE_CLEAN;
                        n_pstart = '0;
                        n_pcount = '0;
                    end
                    n_ridx    = '0;
                    n_armed   = 1'b1;
                    n_wpos    = '0;
                    n_wrapped = 1'b0;
                    o_res.valid = 1'b1;
                    o_res.kind  = crlog_pkg::KIND_BOOT;
                    o_res.pend  = n_pvalid;
                    o_res.cause = n_cause;
                    o_res.len   = crlog_pkg::LEN_W'(n_pcount);
                end
                crlog_pkg::CMD_READ: begin
                    o_res.valid = 1'b1;
                    if (can_read) begin
                        o_mem.re   = 1'b1;
                        o_res.kind = crlog_pkg::KIND_BYTE;
                        o_res.last = (r_ridx + 1'b1) == r_pcount;
                        n_ridx     = r_ridx + 1'b1;
                    end else begin
                        o_res.kind = crlog_pkg::KIND_NONE;
                    end
                end
                default: begin
                    // unknown command is dropped
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_wpos    <= '0;
            r_wrapped <= 1'b0;
            r_armed   <= 1'b0;
            r_pvalid  <= 1'b0;
            r_pstart  <= '0;
            r_pcount  <= '0;
            r_ridx    <= '0;
            r_cause   <= '0;
        end else begin
            r_bank    <= n_bank;
            r_wpos    <= n_wpos;
            r_wrapped <= n_wrapped;
            r_armed   <= n_armed;
            r_pvalid  <= n_pvalid;
            r_pstart  <= n_pstart;
            r_pcount  <= n_pcount;
            r_ridx    <= n_ridx;
            r_cause   <= n_cause;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crash_log_ring_capture.sv
// throughput: one request a cycle while a result stage is free; with the sink
//   always ready, requests with a result still meet stalls, as the input
//   waits whenever the wait stage and the output register are both full
// reset: control state clears under synchronous reset; the two-bank log memory is not
//   cleared and holds bytes only once they are written
// ---------------------------------------------------------------------------
// crash_log_ring_capture
// crash log capture ring with bank swap on crash boot and report readout
// ---------------------------------------------------------------------------
`default_nettype none

`include "crash_log_ring_capture_defines.svh"

module crash_log_ring_capture (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // log_byte[7:0], reset_cause[10:8], zero pad
    input  wire logic [1:0]  i_s_tuser,   // command[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // report_byte[7:0], report_pending[8], report_cause[11:9],
    // report_length[21:12], zero pad
    output logic      [23:0] o_m_tdata,
    output logic      [1:0]  o_m_tuser,   // result_kind[1:0]
    output logic             o_m_tlast    // is_last
);

    logic                            s_accept;
    crlog_pkg::t_mem_req             mem_req;
    crlog_pkg::t_res                 res;
    logic [crlog_pkg::BYTE_W-1:0]    ram_rdata;

    logic                            r_a_valid;
    crlog_pkg::t_res                 r_a_res;
    logic                            a_move;

    logic                            r_out_valid;
    crlog_pkg::t_res                 r_out_res;
    logic [crlog_pkg::BYTE_W-1:0]    r_out_byte;

    assign s_accept = i_s_tvalid && o_s_tready;

    // state and address control
    crlog_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_accept),
        .i_command     (i_s_tuser),
        .i_log_byte    (i_s_tdata[7:0]),
        .i_reset_cause (i_s_tdata[10:8]),
        .o_mem         (mem_req),
        .o_res         (res)
    );

    // two log banks side by side
    crlog_ram #(
        .WIDTH (crlog_pkg::BYTE_W),
        .DEPTH (crlog_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (ram_rdata)
    );

    // take a request when the wait stage or the output register is empty
    assign o_s_tready = !r_a_valid || !r_out_valid;
    assign a_move     = r_a_valid && (!r_out_valid || i_m_tready);

    // wait stage for the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_accept) begin
            r_a_valid <= res.valid;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_res <= res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_out_res  <= r_a_res;
            r_out_byte <= (r_a_res.kind == crlog_pkg::KIND_BYTE) ?
                          crlog_pkg::sanitize(ram_rdata) : '0;
        end
    end

    // result packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_res.kind;
    assign o_m_tlast  = r_out_res.last;
    assign o_m_tdata  = {2'b00, r_out_res.len, r_out_res.cause, r_out_res.pend, r_out_byte};

    // checks
    `CRLOG_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n,
        !r_a_valid, o_s_tready, "request refused with the wait stage empty")
    `CRLOG_ASSERT_NOW(a_last_only_on_byte, i_clk, i_rst_n,
        o_m_tvalid && o_m_tlast, o_m_tuser == crlog_pkg::KIND_BYTE,
        "last mark on a result that is not a report byte")
    `CRLOG_ASSERT_NOW(a_byte_zero_off_kind, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser != crlog_pkg::KIND_BYTE, o_m_tdata[7:0] == 8'h00,
        "report byte set on a non-byte result")
    `CRLOG_ASSERT_NEXT(a_stage_drains, i_clk, i_rst_n,
        r_a_valid && !r_out_valid, r_out_valid,
        "wait stage did not move into an empty output register")

endmodule

`default_nettype wire

FILE: sim/tb_crash_log_ring_capture.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_crash_log_ring_capture
// drives append, boot, read and unknown requests into the crash log capture
// ring and checks every boot status, report byte and empty read result
// against a cycle-free model of the two capture banks, with random gaps on
// the request side and random stalls on the result side
// ---------------------------------------------------------------------------

module tb_crash_log_ring_capture;

    // command and cause codes with no package name
    localparam logic [crlog_pkg::CMD_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam logic [crlog_pkg::CAUSE_W-1:0] CAUSE_UNUSED = 3'd7;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 300;
    localparam int WRAP_READS     = 16;
    localparam int MAX_REPORTED   = 10;

    // one predicted result
    typedef struct packed {
        logic [crlog_pkg::KIND_W-1:0]  kind;
        logic [crlog_pkg::BYTE_W-1:0]  data;
        logic                          last;
        logic                          pend;
        logic [crlog_pkg::CAUSE_W-1:0] cause;
        logic [crlog_pkg::LEN_W-1:0]   len;
    } t_ring_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [15:0]       i_s_tdata;   // log_byte[7:0], reset_cause[10:8], zero pad
    logic [1:0]        i_s_tuser;   // command[1:0]
    logic              o_m_tvalid;
    logic              i_m_tready;
    // report_byte[7:0], report_pending[8], report_cause[11:9],
    // report_length[21:12], zero pad
    logic [23:0]       o_m_tdata;
    logic [1:0]        o_m_tuser;   // result_kind[1:0]
    logic              o_m_tlast;   // is_last

    // model of the capture banks and report pointers
    logic [crlog_pkg::BYTE_W-1:0]  log_mem [0:2*crlog_pkg::RING_DEPTH-1];
    int                            cap_bank;
    int                            wr_pos;
    bit                            wrapped;
    bit                            armed;
    bit                            pend_valid;
    int                            pend_start;
    int                            pend_count;
    int                            rd_idx;
    logic [crlog_pkg::CAUSE_W-1:0] saved_cause;

    t_ring_result      ring_results_q[$];
    t_ring_result      got;
    t_ring_result      want;
    int                fail_count;
    int                items_sent;
    int                idle_cycles;
    int                ready_hold;
    bit                no_idle;

    crash_log_ring_capture DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // printable filter, newline and tab kept
    function automatic logic [crlog_pkg::BYTE_W-1:0] clean_char(
        input logic [crlog_pkg::BYTE_W-1:0] b);
        bit printable;
        printable = (b >= crlog_pkg::CHAR_LOW) && (b <= crlog_pkg::CHAR_HIGH);
        return (printable || b == crlog_pkg::CHAR_NL || b == crlog_pkg::CHAR_TAB) ?
               b : crlog_pkg::CHAR_DOT;
    endfunction

    // random byte for the log_byte field
    function automatic logic [crlog_pkg::BYTE_W-1:0] rand_byte();
        return crlog_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // random cause within a range
    function automatic logic [crlog_pkg::CAUSE_W-1:0] rand_cause(input int lo, input int hi);
        return crlog_pkg::CAUSE_W'($urandom_range(lo, hi));
    endfunction

    // apply one accepted request to the model and queue its result, if it has one
    task automatic ring_apply(input logic [crlog_pkg::CMD_W-1:0] cmd,
                              input logic [crlog_pkg::BYTE_W-1:0] lbyte,
                              input logic [crlog_pkg::CAUSE_W-1:0] cause);
        t_ring_result r;
        int           pos;
        bit           crash;
        r = '0;
        case (cmd)
            crlog_pkg::CMD_APPEND: begin
                if (armed) begin
                    log_mem[cap_bank * crlog_pkg::RING_DEPTH + wr_pos] = lbyte;
                    wr_pos++;
                    if (wr_pos >= crlog_pkg::RING_DEPTH) begin
                        wr_pos  = 0;
                        wrapped = 1'b1;
                    end
                end
            end
            crlog_pkg::CMD_BOOT: begin
                crash = (cause >= crlog_pkg::CAUSE_FIRST_CRASH) &&
                        (cause <= crlog_pkg::CAUSE_LAST_CRASH);
                if (crash && armed && (wr_pos > 0 || wrapped)) begin
                    pend_valid  = 1'b1;
                    saved_cause = cause;
                    pend_start  = wrapped ? wr_pos : 0;
                    pend_count  = wrapped ? crlog_pkg::RING_DEPTH : wr_pos;
                    cap_bank    = 1 - cap_bank;
                end else begin
                    pend_valid  = 1'b0;
                    saved_cause = crlog_pkg::CAUSE_CLEAN;
                    pend_start  = 0;
                    pend_count  = 0;
                end
                rd_idx  = 0;
                armed   = 1'b1;
                wr_pos  = 0;
                wrapped = 1'b0;
                r.kind  = crlog_pkg::KIND_BOOT;
                r.pend  = pend_valid;
                r.cause = saved_cause;
                r.len   = pend_count[crlog_pkg::LEN_W-1:0];
                ring_results_q.push_back(r);
            end
            crlog_pkg::CMD_READ: begin
                if (pend_valid && rd_idx < pend_count) begin
                    pos    = (pend_start + rd_idx) % crlog_pkg::RING_DEPTH;
                    r.kind = crlog_pkg::KIND_BYTE;
                    r.data = clean_char(log_mem[(1 - cap_bank) * crlog_pkg::RING_DEPTH + pos]);
                    r.last = (rd_idx + 1 == pend_count);
                    rd_idx++;
                end else begin
                    r.kind = crlog_pkg::KIND_NONE;
                end
                ring_results_q.push_back(r);
            end
            default: begin
                // unknown command is dropped
            end
        endcase
    endtask

    // request gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // send one request and update the model when it is taken
    task automatic send_request(input logic [crlog_pkg::CMD_W-1:0] cmd,
                                input logic [crlog_pkg::BYTE_W-1:0] lbyte,
                                input logic [crlog_pkg::CAUSE_W-1:0] cause);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {5'd0, cause, lbyte};
        do @(posedge i_clk); while (!o_s_tready);
        ring_apply(cmd, lbyte, cause);
        items_sent++;
    endtask

    // stop sending until every queued result has come back
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (ring_results_q.size() != 0) @(posedge i_clk);
    endtask

    // appends and reads before the first boot, unknown command, unarmed boot
    task automatic test_idle_before_boot();
        send_request(crlog_pkg::CMD_APPEND, 8'hAA, crlog_pkg::CAUSE_CLEAN);
        send_request(crlog_pkg::CMD_READ, 8'h00, crlog_pkg::CAUSE_CLEAN);
        send_request(CMD_UNUSED, 8'hFF, CAUSE_UNUSED);
        send_request(crlog_pkg::CMD_BOOT, 8'h55, crlog_pkg::CAUSE_LAST_CRASH);
    endtask

    // boundary bytes through the printable filter, then one read past the end
    task automatic test_sanitize_report();
        logic [crlog_pkg::BYTE_W-1:0] edge_bytes [8];
        edge_bytes = '{8'h00, crlog_pkg::CHAR_TAB, crlog_pkg::CHAR_NL, 8'h1F,
                       crlog_pkg::CHAR_LOW, crlog_pkg::CHAR_HIGH, 8'h7F, 8'hFF};
        foreach (edge_bytes[k]) begin
            send_request(crlog_pkg::CMD_APPEND, edge_bytes[k], crlog_pkg::CAUSE_W'(k));
            if (k == 3)
                send_request(CMD_UNUSED, 8'h41, crlog_pkg::CAUSE_CLEAN);
        end
        send_request(crlog_pkg::CMD_BOOT, 8'h00, crlog_pkg::CAUSE_FIRST_CRASH);
        repeat (9) send_request(crlog_pkg::CMD_READ, 8'hFF, CAUSE_UNUSED);
    endtask

    // cause 7 drops the old report, crash boot with nothing captured
    task automatic test_no_report_boots();
        send_request(crlog_pkg::CMD_APPEND, 8'h41, crlog_pkg::CAUSE_CLEAN);
        send_request(crlog_pkg::CMD_BOOT, 8'h00, CAUSE_UNUSED);
        send_request(crlog_pkg::CMD_READ, 8'h00, crlog_pkg::CAUSE_CLEAN);
        send_request(crlog_pkg::CMD_BOOT, 8'hFF, crlog_pkg::CAUSE_LAST_CRASH);
    endtask

    // ring that wraps on or a few bytes past its end, report read from its oldest byte
    task automatic test_ring_wrap();
        int extra;
        send_request(crlog_pkg::CMD_BOOT, 8'h00, crlog_pkg::CAUSE_CLEAN);
        no_idle = 1'b1;
        extra = $urandom_range(0, 6);
        repeat (crlog_pkg::RING_DEPTH + extra)
            send_request(crlog_pkg::CMD_APPEND, rand_byte(), rand_cause(0, 7));
        send_request(crlog_pkg::CMD_BOOT, rand_byte(), rand_cause(1, 6));
        no_idle = 1'b0;
        repeat (WRAP_READS) send_request(crlog_pkg::CMD_READ, rand_byte(), CAUSE_UNUSED);
    endtask

    // capture sessions of random size closed by a boot, reads in between
    task automatic test_random_sessions();
        int                            stop_at;
        int                            n_app;
        int                            n_rd;
        int                            r;
        logic [crlog_pkg::CAUSE_W-1:0] cause;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 75)
                n_app = $urandom_range(0, 24);
            else if (r < 95)
                n_app = $urandom_range(25, 90);
            else
                n_app = 0;
            repeat (n_app) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(crlog_pkg::CMD_READ, rand_byte(), rand_cause(0, 7));
                if ($urandom_range(0, 39) == 0)
                    send_request(CMD_UNUSED, rand_byte(), rand_cause(0, 7));
                send_request(crlog_pkg::CMD_APPEND, rand_byte(), rand_cause(0, 7));
            end
            r = $urandom_range(0, 99);
            if (r < 75)
                cause = rand_cause(1, 6);
            else if (r < 85)
                cause = crlog_pkg::CAUSE_CLEAN;
            else if (r < 95)
                cause = CAUSE_UNUSED;
            else
                cause = rand_cause(0, 7);
            send_request(crlog_pkg::CMD_BOOT, rand_byte(), cause);
            n_rd = $urandom_range(0, n_app + 3);
            repeat (n_rd) send_request(crlog_pkg::CMD_READ, rand_byte(), rand_cause(0, 7));
            if ($urandom_range(0, 14) == 0)
                hold_until_drained();
        end
        no_idle = 1'b0;
    endtask

    // result side ready with random stalls, held for a random number of cycles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_idle) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) < 70);
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 3);
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind  = o_m_tuser;
            got.data  = o_m_tdata[7:0];
            got.last  = o_m_tlast;
            got.pend  = o_m_tdata[8];
            got.cause = o_m_tdata[11:9];
            got.len   = o_m_tdata[21:12];
            if (ring_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTED)
                    $display("%t: unexpected result kind %0d data %02h", $realtime,
                             got.kind, got.data);
            end else begin
                want = ring_results_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED) begin
                        $display("%t: exp kind %0d data %02h last %0b pend %0b cause %0d len %0d",
                                 $realtime, want.kind, want.data, want.last, want.pend,
                                 want.cause, want.len);
                        $display("%t: got kind %0d data %02h last %0b pend %0b cause %0d len %0d",
                                 $realtime, got.kind, got.data, got.last, got.pend,
                                 got.cause, got.len);
                    end
                end
            end
        end
    end

    // stop a hung run: too many cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("crash_log_ring_capture test failed");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = crlog_pkg::CMD_APPEND;
        no_idle     = 1'b0;
        items_sent  = 0;
        cap_bank    = 0;
        wr_pos      = 0;
        wrapped     = 1'b0;
        armed       = 1'b0;
        pend_valid  = 1'b0;
        pend_start  = 0;
        pend_count  = 0;
        rd_idx      = 0;
        saved_cause = crlog_pkg::CAUSE_CLEAN;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_before_boot();
        test_sanitize_report();
        test_no_report_boots();
        hold_until_drained();
        test_ring_wrap();
        test_random_sessions();

        // drain and settle
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (ring_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && ring_results_q.size() == 0) begin
            $display("crash_log_ring_capture test passed");
        end else begin
            $display("crash_log_ring_capture test failed");
        end
        $finish;
    end

endmodule
